### src/dmsr_pkg.sv
// ----------------------------------------------------------------------------
// dmsr_pkg: shared constants and types for the decimal scale reducer
// Limb geometry of the cell row and the reciprocal used for the
// divide-by-ten step inside each cell.
// ----------------------------------------------------------------------------
package dmsr_pkg;

  localparam int unsigned MantW    = 96;
  localparam int unsigned LimbW    = 12;
  localparam int unsigned NumLimbs = MantW / LimbW;
  localparam int unsigned ShiftW   = 8;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned RemW     = 4;

  // 2^96 < 10^29, so after 29 divisions the quotient is zero and a 30th
  // division already yields the zero digit that every later one yields.
  localparam int unsigned MaxDiv   = 30;
  localparam int unsigned CntW     = $clog2(MaxDiv + 1);
  localparam int unsigned StepW    = $clog2(MaxDiv + NumLimbs);

  // floor(x / 10) == (x * RecipMul) >> RecipShift for every x below 2^18.
  // The cell input {rem, limb} stays below 10 * 2^LimbW.
  localparam int unsigned CellInW    = RemW + LimbW;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipW     = 17;
  localparam logic [RecipW-1:0] RecipMul = RecipW'(52429);
  localparam logic [DigitW-1:0] Radix    = DigitW'(10);

  typedef struct packed {
    logic load;
    logic act;
  } cell_ctl_t;

endpackage

### src/dmsr_cell.sv
// ----------------------------------------------------------------------------
// dmsr_cell: one limb of the divide-by-ten chain
// Holds one limb of the mantissa and divides {remainder in, limb} by ten
// when enabled, passing its own remainder to the next lower cell.
// ----------------------------------------------------------------------------
module dmsr_cell
  import dmsr_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [LimbW-1:0] limb_i,
  input  logic [RemW-1:0]  rem_i,
  output logic [LimbW-1:0] limb_o,
  output logic [RemW-1:0]  rem_o
);

  logic [LimbW-1:0]                limb_q, limb_d;
  logic [RemW-1:0]                 rem_q, rem_d;
  logic [CellInW-1:0]              x;
  logic [CellInW+RecipW-1:0]       prod;
  logic [LimbW-1:0]                quo;
  logic [LimbW+DigitW-1:0]         quo_x10;

  always_comb begin
    x       = {rem_i, limb_q};
    prod    = CellInW'(x) * RecipMul;
    quo     = prod[RecipShift +: LimbW];
    quo_x10 = quo * Radix;
    limb_d  = limb_q;
    rem_d   = rem_q;
    if (ctl_i.load) begin
      limb_d = limb_i;
      rem_d  = '0;
    end else if (ctl_i.act) begin
      limb_d = quo;
      rem_d  = RemW'(x - CellInW'(quo_x10));
    end
  end

  always_ff @(posedge clk_i) begin
    limb_q <= limb_d;
    rem_q  <= rem_d;
  end

  assign limb_o = limb_q;
  assign rem_o  = rem_q;

endmodule

### src/decimal_mantissa_scale_reduce_unit.sv
// ----------------------------------------------------------------------------
// decimal_mantissa_scale_reduce_unit: divide a 96-bit mantissa by 10^n
// Runs n' = min(n, 30) divisions per input word. A row of eight 12-bit
// cells runs them as a skewed wavefront, one division per cell per cycle,
// and the skew of the lower cells is added to the n' divisions. A new word
// is taken only once the previous result is in the output register.
// Reset: asynchronous, active low; clears control, no clearing pass.
// ----------------------------------------------------------------------------
module decimal_mantissa_scale_reduce_unit
  import dmsr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [63:0] mantissa_low, [95:64] mantissa_high, [103:96] shift_digits
  input  logic [103:0]  s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [63:0] quotient_low, [95:64] quotient_high, [96] dropped_nonzero,
  // [100:97] final_digit, [103:101] zero
  output logic [103:0]  m_axis_tdata_o
);

  logic                busy_q, busy_d;
  logic [StepW-1:0]    t_q, t_d;
  logic [CntW-1:0]     n_q, n_d;
  logic                bot_act_q, bot_act_d;
  logic                dropped_q, dropped_d;
  logic                out_valid_q, out_valid_d;
  logic [MantW-1:0]    out_mant_q, out_mant_d;
  logic                out_drop_q, out_drop_d;
  logic [DigitW-1:0]   out_digit_q, out_digit_d;

  logic                in_acc, out_acc, finish, drop_now;
  logic [ShiftW-1:0]   shift_in;
  logic [StepW-1:0]    t_end;
  logic [MantW-1:0]    mant_in, mant_cur;
  cell_ctl_t           ctl    [NumLimbs];
  logic [RemW-1:0]     rem_in [NumLimbs];
  logic [RemW-1:0]     rem_out[NumLimbs];

  assign mant_in  = s_axis_tdata_i[MantW-1:0];
  assign shift_in = s_axis_tdata_i[MantW +: ShiftW];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = out_valid_q && m_axis_tready_i;
  assign t_end    = StepW'(n_q) + StepW'(NumLimbs - 1);
  assign finish   = busy_q && (t_q == t_end) && (!out_valid_q || m_axis_tready_i);
  // Digit just produced by the bottom cell in the previous cycle.
  assign drop_now = bot_act_q && (rem_out[0] != '0);

  // Cell j sits NumLimbs-1-j steps below the top and runs division k at
  // step k + (NumLimbs-1-j), so the remainder it takes from above is ready.
  for (genvar j = 0; j < NumLimbs; j++) begin : g_cell
    localparam logic [StepW-1:0] Skew = StepW'(NumLimbs - 1 - j);
    assign ctl[j].load = in_acc;
    assign ctl[j].act  = busy_q && (t_q >= Skew) && (t_q < StepW'(n_q) + Skew);
    if (j == NumLimbs - 1) begin : g_top
      assign rem_in[j] = '0;
    end else begin : g_mid
      assign rem_in[j] = rem_out[j+1];
    end
    dmsr_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[j]),
      .limb_i (mant_in[j*LimbW +: LimbW]),
      .rem_i  (rem_in[j]),
      .limb_o (mant_cur[j*LimbW +: LimbW]),
      .rem_o  (rem_out[j])
    );
  end

  always_comb begin
    busy_d      = busy_q;
    t_d         = t_q;
    n_d         = n_q;
    bot_act_d   = ctl[0].act;
    dropped_d   = dropped_q | drop_now;
    out_valid_d = out_valid_q;
    out_mant_d  = out_mant_q;
    out_drop_d  = out_drop_q;
    out_digit_d = out_digit_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      busy_d    = 1'b1;
      t_d       = '0;
      n_d       = (shift_in >= ShiftW'(MaxDiv)) ? CntW'(MaxDiv) : CntW'(shift_in);
      dropped_d = 1'b0;
      bot_act_d = 1'b0;
    end else if (finish) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      out_mant_d  = mant_cur;
      out_drop_d  = dropped_q | drop_now;
      out_digit_d = DigitW'(rem_out[0]);
    end else if (busy_q && t_q != t_end) begin
      t_d = t_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      t_q         <= '0;
      n_q         <= '0;
      bot_act_q   <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      t_q         <= t_d;
      n_q         <= n_d;
      bot_act_q   <= bot_act_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mant_q  <= out_mant_d;
    out_drop_q  <= out_drop_d;
    out_digit_q <= out_digit_d;
  end

  assign s_axis_tready_o = !busy_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_digit_q, out_drop_q, out_mant_q};

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (t_q <= t_end))
    else $error("step counter ran past the end of the wavefront");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (busy_q && t_q == '0 && !dropped_q))
    else $error("accepted word did not start a fresh run");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_digit_q <= DigitW'(9)))
    else $error("final digit out of decimal range");

  a_digit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_digit_q != '0) |-> out_drop_q)
    else $error("nonzero final digit without the dropped flag");

  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (!busy_q && out_valid_q))
    else $error("finished run did not land in the output register");

endmodule

### dv/mantissa_reduce_checker.sv
// ----------------------------------------------------------------------------
// mantissa_reduce_checker: predicts and checks the decimal scale reducer
// Watches both stream channels. Each accepted input word is reduced by its
// own shift count, and the result is queued. Each accepted output word is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module mantissa_reduce_checker
  import dmsr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  // [95:0] mantissa, [103:96] shift_digits
  input  logic [103:0] s_axis_tdata_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // [95:0] quotient, [96] dropped_nonzero, [100:97] final_digit, [103:101] zero
  input  logic [103:0] m_axis_tdata_i,
  output int           pending_o,
  output int           results_o,
  output int           fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DecimalBase = 10;

  typedef struct packed {
    logic [MantW-1:0]  quotient;
    logic              dropped_nonzero;
    logic [DigitW-1:0] final_digit;
  } reduction_t;

  reduction_t pending_reductions[$];

  // Once the value is zero every further division drops a zero digit, so
  // the loop stops there with the digit cleared and the flag kept.
  function automatic reduction_t divide_by_ten_n(logic [MantW-1:0] mant,
                                                 logic [ShiftW-1:0] digits);
    reduction_t       r;
    logic [MantW-1:0] value;
    r     = '0;
    value = mant;
    for (int k = 0; k < int'(digits); k++) begin
      if (value == '0) begin
        r.final_digit = '0;
        break;
      end
      r.final_digit = DigitW'(value % DecimalBase);
      if (r.final_digit != '0) r.dropped_nonzero = 1'b1;
      value = value / DecimalBase;
    end
    r.quotient = value;
    return r;
  endfunction

  int pending_cnt = 0;
  int result_cnt  = 0;
  int fail_cnt    = 0;

  assign pending_o    = pending_cnt;
  assign results_o    = result_cnt;
  assign fail_count_o = fail_cnt;

  always @(posedge clk_i) begin
    reduction_t  want;
    logic [2:0]  pad;
    int          errs;
    int          delta;
    errs  = 0;
    delta = 0;
    if (rst_ni) begin
      // No word leaves in the cycle it arrives, so outputs are taken first.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_reductions.size() == 0) begin
          $error("output word with no expected result: %h", m_axis_tdata_i);
          errs++;
        end else begin
          want = pending_reductions.pop_front();
          delta--;
          pad  = m_axis_tdata_i[103:101];
          if (m_axis_tdata_i[63:0] !== want.quotient[63:0]) begin
            $error("quotient_low: expected %h, got %h",
                   want.quotient[63:0], m_axis_tdata_i[63:0]);
            errs++;
          end
          if (m_axis_tdata_i[95:64] !== want.quotient[95:64]) begin
            $error("quotient_high: expected %h, got %h",
                   want.quotient[95:64], m_axis_tdata_i[95:64]);
            errs++;
          end
          if (m_axis_tdata_i[96] !== want.dropped_nonzero) begin
            $error("dropped_nonzero: expected %b, got %b",
                   want.dropped_nonzero, m_axis_tdata_i[96]);
            errs++;
          end
          if (m_axis_tdata_i[100:97] !== want.final_digit) begin
            $error("final_digit: expected %0d, got %0d",
                   want.final_digit, m_axis_tdata_i[100:97]);
            errs++;
          end
          if (pad !== 3'b000) begin
            $error("padding: expected %b, got %b", 3'b000, pad);
            errs++;
          end
        end
        result_cnt <= result_cnt + 1;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_reductions.push_back(
          divide_by_ten_n(s_axis_tdata_i[95:0], s_axis_tdata_i[103:96]));
        delta++;
      end
      pending_cnt <= pending_cnt + delta;
      fail_cnt    <= fail_cnt + errs;
    end
  end

endmodule

### dv/decimal_mantissa_scale_reduce_unit_tb.sv
// ----------------------------------------------------------------------------
// decimal_mantissa_scale_reduce_unit_tb: stimulus for the decimal reducer
// Sends directed mantissas at the edges of the value and shift ranges, then
// random words with random gaps and output stalls, including one long stall
// that backs the block up. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module decimal_mantissa_scale_reduce_unit_tb
  import dmsr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords   = 400;
  localparam int HoldAfter     = 120;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 60;

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  int pending;
  int results;
  int fail_count;

  int words_sent       = 0;
  int zero_shift_words = 0;
  int long_shift_words = 0;
  bit steady_phase     = 1'b0;

  decimal_mantissa_scale_reduce_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  mantissa_reduce_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .pending_o       (pending),
    .results_o       (results),
    .fail_count_o    (fail_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short idle stretches, a few long ones, none in the steady phase.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_phase || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [MantW-1:0] pow_ten(int k);
    logic [MantW-1:0] p;
    p = MantW'(1);
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Valid stays high between back-to-back words; it drops only for a gap.
  task automatic send_mantissa(input logic [MantW-1:0] mant,
                               input logic [ShiftW-1:0] digits);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {digits, mant};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (digits == '0) zero_shift_words++;
    if (digits >= 30) long_shift_words++;
  endtask

  // Output side: random stall and run lengths, plus one long hold-off once
  // HoldAfter words have been sent, to fill the block and stall its input.
  initial begin
    bit held;
    int stall;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && words_sent >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [MantW-1:0]  mant;
    logic [ShiftW-1:0] digits;
    int                k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words.
    send_mantissa('0, 8'd0);
    send_mantissa('1, 8'd0);
    send_mantissa('1, 8'd1);
    send_mantissa('1, 8'd29);
    send_mantissa('1, 8'd30);
    send_mantissa('1, 8'd255);
    send_mantissa('0, 8'd255);
    send_mantissa('0, 8'd1);
    send_mantissa(96'd1, 8'd1);
    // Reaches zero after one division; the flag must survive the rest.
    send_mantissa(96'd9, 8'd2);
    send_mantissa(96'd100, 8'd2);
    send_mantissa(pow_ten(28), 8'd28);
    send_mantissa(pow_ten(28), 8'd29);
    send_mantissa(pow_ten(28) - 1, 8'd28);
    // Remainders carried across the 32-bit and 64-bit boundaries.
    send_mantissa(96'h1_0000_0000_0000_0000, 8'd1);
    send_mantissa(96'h1_0000_0000, 8'd1);
    send_mantissa({32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA}, 8'h55);
    send_mantissa({32'h5555_5555, 64'h5555_5555_5555_5555}, 8'hAA);
    send_mantissa(96'd12345678901234567890, 8'd5);
    send_mantissa({32'hFFFF_FFFF, 64'h0}, 8'd3);
    send_mantissa({32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd20);
    send_mantissa(96'd5, 8'd255);

    for (int n = 0; n < RandomWords; n++) begin
      steady_phase = (n >= 200 && n < 260);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mant = {$urandom, $urandom, $urandom};
        4:          mant = MantW'($urandom_range(0, 999));
        5:          mant = MantW'($urandom);
        6: begin
          // Trailing zeros give reductions that drop no nonzero digit when the shift is at most k.
          k    = $urandom_range(1, 20);
          mant = ({$urandom, $urandom, $urandom} / pow_ten(k)) * pow_ten(k);
        end
        7: begin
          k    = $urandom_range(0, 28);
          mant = pow_ten(k) + $urandom_range(0, 3) - $urandom_range(0, 3);
        end
        8:       mant = MantW'({$urandom, $urandom});
        default: mant = '1 - $urandom_range(0, 15);
      endcase
      if ($urandom_range(0, 3) != 0) digits = ShiftW'($urandom_range(0, 31));
      else digits = ShiftW'($urandom_range(0, 255));
      send_mantissa(mant, digits);
    end
    steady_phase = 1'b0;
    s_axis_tvalid <= 1'b0;

    // The count for the last word taken only settles after its edge.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d mantissas: %0d with no shift, %0d shifted by 30 digits or more.",
             words_sent, zero_shift_words, long_shift_words);
    $display("Checked %0d reduced results, with one long output stall.", results);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
src/dmsr_pkg.sv
src/dmsr_cell.sv
src/decimal_mantissa_scale_reduce_unit.sv
dv/mantissa_reduce_checker.sv
dv/decimal_mantissa_scale_reduce_unit_tb.sv
